// File: hdl/lkc_pkg.sv
// lkc_pkg: shared types and constants for the key cache lookup unit.
// No dependencies.
`timescale 1ns / 1ps
package lkc_pkg;
  localparam int KEY_BITS  = 352;
  localparam int SLOT_BITS = 9;
  typedef logic [KEY_BITS-1:0] key_t;
endpackage

// File: hdl/lru_key_cache_lookup_unit.sv
// lru_key_cache_lookup_unit: fully associative key store with LRU replacement.
// Depends on lkc_pkg.
//
// channel | handshake          | payload
// in      | start & !busy      | in_tint_*, in_add_*, in_screen_*, in_base_handle
// out     | out_valid (1 cycle)| out_hit, out_slot, out_evicted
//
// A request scans the key memory one slot per cycle up to the fill count, then
// updates the links in S_RDO or S_RDN and S_PUSH as needed and shows the result in
// S_DONE. A new request is taken only back in S_IDLE, after the result. busy is
// high from accept to result.
// Synchronous active-low reset clears the control state only; memories hold
// undefined data until written and only slots below the fill count are read.
// The receiver cannot stall; each result shows for one cycle.
`timescale 1ns / 1ps
module lru_key_cache_lookup_unit
  import lkc_pkg::*;
#(
  parameter int CAPACITY = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_tint_red,
  input  logic [31:0] in_tint_green,
  input  logic [31:0] in_tint_blue,
  input  logic [31:0] in_add_red,
  input  logic [31:0] in_add_green,
  input  logic [31:0] in_add_blue,
  input  logic [31:0] in_screen_red,
  input  logic [31:0] in_screen_green,
  input  logic [31:0] in_screen_blue,
  input  logic [63:0] in_base_handle,
  output logic        out_valid,
  output logic        out_hit,
  output logic [8:0]  out_slot,
  output logic        out_evicted
);
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_RDN = 3'd2,
                         S_RDO = 3'd3, S_PUSH = 3'd5, S_DONE = 3'd6;

  key_t key_mem [CAPACITY];
  logic [AW-1:0] newer_mem [CAPACITY];
  logic [AW-1:0] older_mem [CAPACITY];

  logic [2:0]    state_r, state_nxt;
  key_t          key_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] newest_r, newest_nxt, oldest_r, oldest_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          rd_pend_r;
  logic [AW-1:0] rd_slot_r;
  key_t          rd_key_r;
  logic [AW-1:0] s_r, s_nxt;
  logic          hit_r, hit_nxt, ev_r, ev_nxt;
  logic          first_r, first_nxt;

  // link memory single read port result
  logic [AW-1:0] nrd_r, ord_r;
  logic [AW-1:0] lrd_addr;

  // link write ports
  logic          nwe, owe;
  logic [AW-1:0] nwa, nwd, owa, owd;
  logic          kwe;
  logic [AW-1:0] kwa;
  logic          rd_en;

  always_ff @(posedge clk) begin
    if (rd_en) rd_key_r <= key_mem[idx_r[AW-1:0]];
    if (kwe) key_mem[kwa] <= key_r;
  end

  always_ff @(posedge clk) begin
    nrd_r <= newer_mem[lrd_addr];
    ord_r <= older_mem[lrd_addr];
    if (nwe) newer_mem[nwa] <= nwd;
    if (owe) older_mem[owa] <= owd;
  end

  logic match;
  assign match = rd_pend_r && (rd_key_r == key_r);

  always_comb begin
    state_nxt = state_r; count_nxt = count_r; newest_nxt = newest_r;
    oldest_nxt = oldest_r; idx_nxt = idx_r; s_nxt = s_r;
    hit_nxt = hit_r; ev_nxt = ev_r; first_nxt = first_r;
    rd_en = 1'b0; kwe = 1'b0; kwa = s_r;
    nwe = 1'b0; nwa = s_r; nwd = s_r; owe = 1'b0; owa = s_r; owd = newest_r;
    lrd_addr = s_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_SCAN; idx_nxt = '0;
        end
      end
      S_SCAN: begin
        if (match) begin
          // hit: move rd_slot to newest
          hit_nxt = 1'b1; ev_nxt = 1'b0; s_nxt = rd_slot_r;
          lrd_addr = rd_slot_r;
          state_nxt = (rd_slot_r == newest_r) ? S_DONE : S_RDN;
        end else if (idx_r < count_r) begin
          rd_en = 1'b1; idx_nxt = idx_r + 1'b1;
        end else if (!rd_pend_r) begin
          hit_nxt = 1'b0;
          if (count_r == CAP) begin
            s_nxt = oldest_r; ev_nxt = 1'b1; first_nxt = 1'b0;
            lrd_addr = oldest_r; state_nxt = S_RDO;
          end else begin
            s_nxt = count_r[AW-1:0]; ev_nxt = 1'b0;
            first_nxt = (count_r == '0); count_nxt = count_r + 1'b1;
            state_nxt = S_PUSH;
          end
        end
      end
      S_RDO: begin
        // evict: oldest advances to newer link of the victim
        oldest_nxt = nrd_r; kwe = 1'b1; state_nxt = S_PUSH;
      end
      S_RDN: begin
        if (s_r == oldest_r) begin
          oldest_nxt = nrd_r; state_nxt = S_PUSH;
        end else begin
          // unlink: newer[o]=n, older[n]=o
          nwe = 1'b1; nwa = ord_r; nwd = nrd_r;
          owe = 1'b1; owa = nrd_r; owd = ord_r;
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!hit_r && !ev_r) kwe = 1'b1;
        if (first_r) begin
          newest_nxt = s_r; oldest_nxt = s_r;
        end else begin
          owe = 1'b1; owa = s_r; owd = newest_r;
          nwe = 1'b1; nwa = newest_r; nwd = s_r;
          newest_nxt = s_r;
        end
        state_nxt = S_DONE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; count_r <= '0; newest_r <= '0; oldest_r <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt; count_r <= count_nxt; newest_r <= newest_nxt;
      oldest_r <= oldest_nxt;
      rd_pend_r <= rd_en;
    end
    if (state_r == S_IDLE && start)
      key_r <= {in_tint_red, in_tint_green, in_tint_blue, in_add_red, in_add_green,
                in_add_blue, in_screen_red, in_screen_green, in_screen_blue,
                in_base_handle};
    idx_r <= idx_nxt; s_r <= s_nxt; hit_r <= hit_nxt; ev_r <= ev_nxt;
    first_r <= first_nxt;
    if (rd_en) rd_slot_r <= idx_r[AW-1:0];
  end

  assign busy        = (state_r != S_IDLE);
  assign out_valid   = (state_r == S_DONE);
  assign out_hit     = hit_r;
  assign out_slot    = 9'(s_r);
  assign out_evicted = ev_r;

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) count_r <= CAP)
    else $error("fill count over capacity");
  a_hit_ev: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_evicted)) else $error("hit with eviction");
  a_ev_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> count_r == CAP) else $error("evict when not full");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double result");
endmodule

// File: sim/lkc_lookup_checker.sv
// lkc_lookup_checker: watches the request and result channels of the key cache,
// predicts hit/slot/evicted per accepted request and compares. Depends on lkc_pkg.
`timescale 1ns / 1ps
module lkc_lookup_checker
  import lkc_pkg::*;
#(
  parameter int CAPACITY = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [31:0] in_tint_red,
  input  logic [31:0] in_tint_green,
  input  logic [31:0] in_tint_blue,
  input  logic [31:0] in_add_red,
  input  logic [31:0] in_add_green,
  input  logic [31:0] in_add_blue,
  input  logic [31:0] in_screen_red,
  input  logic [31:0] in_screen_green,
  input  logic [31:0] in_screen_blue,
  input  logic [63:0] in_base_handle,
  input  logic        out_valid,
  input  logic        out_hit,
  input  logic [8:0]  out_slot,
  input  logic        out_evicted,
  output int          fail_count,
  output int          pending,
  output int          hit_count,
  output int          evict_count,
  output int          result_count
);

  typedef struct packed {
    logic                 hit;
    logic [SLOT_BITS-1:0] slot;
    logic                 evicted;
  } lookup_res_t;

  key_t            cached_key [CAPACITY];
  longint unsigned last_use   [CAPACITY];
  int              fill_count;
  longint unsigned use_tick;
  lookup_res_t     expected_lookups[$];

  assign pending = expected_lookups.size();

  // LRU tracked by last-use stamps; the oldest stamp is the victim
  function automatic lookup_res_t lookup_key(key_t k);
    lookup_res_t r;
    int victim;
    r = '0;
    use_tick++;
    for (int s = 0; s < fill_count; s++) begin
      if (cached_key[s] === k) begin
        last_use[s] = use_tick;
        r.hit  = 1'b1;
        r.slot = s[SLOT_BITS-1:0];
        return r;
      end
    end
    if (fill_count >= CAPACITY) begin
      victim = 0;
      for (int s = 1; s < CAPACITY; s++)
        if (last_use[s] < last_use[victim]) victim = s;
      r.evicted = 1'b1;
    end else begin
      victim = fill_count;
      fill_count++;
    end
    cached_key[victim] = k;
    last_use[victim]   = use_tick;
    r.slot = victim[SLOT_BITS-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    lookup_res_t want;
    lookup_res_t got;
    if (!rst_n) begin
      fill_count   = 0;
      use_tick     = 0;
      fail_count   = 0;
      hit_count    = 0;
      evict_count  = 0;
      result_count = 0;
      expected_lookups.delete();
    end else begin
      if (out_valid) begin
        got = '{hit: out_hit, slot: out_slot, evicted: out_evicted};
        result_count++;
        if (expected_lookups.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result hit=%0b slot=%0d evicted=%0b",
                     $time, got.hit, got.slot, got.evicted);
        end else begin
          want = expected_lookups.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch exp hit=%0b slot=%0d ev=%0b got hit=%0b slot=%0d ev=%0b",
                       $time, want.hit, want.slot, want.evicted,
                       got.hit, got.slot, got.evicted);
          end
          if (want.hit) hit_count++;
          if (want.evicted) evict_count++;
        end
      end
      if (start && !busy)
        expected_lookups.insert(expected_lookups.size(),
                                lookup_key({in_tint_red, in_tint_green, in_tint_blue,
                                            in_add_red, in_add_green, in_add_blue,
                                            in_screen_red, in_screen_green,
                                            in_screen_blue, in_base_handle}));
    end
  end

endmodule

// File: sim/tb_lru_key_cache_lookup_unit.sv
// tb_lru_key_cache_lookup_unit: stimulus and verdict for the key cache lookup unit.
// Depends on lkc_pkg, lru_key_cache_lookup_unit and lkc_lookup_checker.
`timescale 1ns / 1ps
module tb_lru_key_cache_lookup_unit
  import lkc_pkg::*;
();

  localparam int CAPACITY   = 512;
  localparam int NUM_RANDOM = 1130;
  localparam int POOL_SIZE  = 800;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_tint_red, in_tint_green, in_tint_blue;
  logic [31:0] in_add_red, in_add_green, in_add_blue;
  logic [31:0] in_screen_red, in_screen_green, in_screen_blue;
  logic [63:0] in_base_handle;
  logic        out_valid;
  logic        out_hit;
  logic [8:0]  out_slot;
  logic        out_evicted;
  int          fail_count, pending, hit_count, evict_count, result_count;

  key_t key_pool [POOL_SIZE];
  key_t recent_keys[$];
  int   idle_pct;

  lru_key_cache_lookup_unit #(.CAPACITY(CAPACITY)) DUT (.*);

  lkc_lookup_checker #(.CAPACITY(CAPACITY)) u_checker (.*);

  always begin
    clk = 1'b0; #1;
    clk = 1'b1; #1;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic key_t random_key();
    key_t k;
    for (int i = 0; i < KEY_BITS / 32; i++) k[i*32 +: 32] = $urandom();
    return k;
  endfunction

  // one request transfer; may idle afterwards per the current idle rate
  task automatic send_key(key_t k);
    start           <= 1'b1;
    in_tint_red     <= k[351:320];
    in_tint_green   <= k[319:288];
    in_tint_blue    <= k[287:256];
    in_add_red      <= k[255:224];
    in_add_green    <= k[223:192];
    in_add_blue     <= k[191:160];
    in_screen_red   <= k[159:128];
    in_screen_green <= k[127:96];
    in_screen_blue  <= k[95:64];
    in_base_handle  <= k[63:0];
    do @(posedge clk); while (busy);
    recent_keys.insert(recent_keys.size(), k);
    if (recent_keys.size() > 64) void'(recent_keys.pop_front());
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  initial begin
    key_t k;
    int   pick;
    start <= 1'b0;
    rst_n <= 1'b0;
    {in_tint_red, in_tint_green, in_tint_blue, in_add_red, in_add_green,
     in_add_blue, in_screen_red, in_screen_green, in_screen_blue, in_base_handle} <= '0;
    idle_pct = 19;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, repeat hits, single-bit near misses in every field
    send_key('0);
    send_key('1);
    send_key('0);
    send_key('1);
    k = random_key();
    send_key(k);
    for (int f = 0; f < 10; f++) send_key(k ^ (key_t'(1) << (f * 32 + $urandom_range(31))));
    send_key(k ^ (key_t'(1) << 351));
    send_key({k[KEY_BITS-1:64], 64'h0});
    send_key(k);
    send_key('0);

    for (int i = 0; i < POOL_SIZE; i++)
      key_pool[i] = (i > 0 && $urandom_range(9) == 0)
                    ? key_pool[i-1] ^ (key_t'(1) << $urandom_range(KEY_BITS - 1))
                    : random_key();

    // random: recent reuse for hits, wide pool for fill and eviction, some fresh keys
    for (int n = 0; n < NUM_RANDOM; n++) begin
      idle_pct = (n < NUM_RANDOM / 3) ? 19 : (n < 2 * NUM_RANDOM / 3) ? 82 : 0;
      pick = $urandom_range(99);
      if (pick < 35 && recent_keys.size() > 0)
        k = recent_keys[$urandom_range(recent_keys.size() - 1)];
      else if (pick < 88)
        k = key_pool[$urandom_range(POOL_SIZE - 1)];
      else
        k = random_key();
      send_key(k);
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (CAPACITY + 16) @(posedge clk);

    $display("Checked %0d lookups: %0d hits, %0d evictions, store capacity %0d.",
             result_count, hit_count, evict_count, CAPACITY);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d failures, %0d results outstanding", fail_count, pending);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
